// ===== hw/rtl/ssew_pkg.sv =====
`timescale 1ns / 1ps

package ssew_pkg;

   localparam int DEPTH = 256;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RIDX_W = 8;
   localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
   localparam int VAL_W = 48;
   localparam int MARK_W = 49;
   localparam int COUNT_W = 9;
   localparam int GRP = 16;
   localparam int NGRP = (DEPTH + GRP - 1) / GRP;

   typedef enum logic [2:0] {
      FN_GATED,
      FN_SYNC,
      FN_HEARTBEAT,
      FN_CLEAR,
      FN_READ
   } func_type;

   typedef struct packed {
      logic [VAL_W-1:0] stamp;
      logic [VAL_W-1:0] price;
      logic [VAL_W-1:0] quantity;
      logic             side;
   } entry_type;

   typedef struct packed {
      logic              ins_en;
      logic              full;
      entry_type         rec;
      logic [CNT_W-1:0]  count;
      logic [RIDX_W-1:0] read_index;
   } cell_cmd_type;

   typedef struct packed {
      logic               changed;
      logic [COUNT_W-1:0] count;
      logic [MARK_W-1:0]  mark;
      logic               rd_valid;
      entry_type          rd;
   } rsp_type;

endpackage

// ===== hw/rtl/ssew_req_if.sv =====
`timescale 1ns / 1ps

interface ssew_req_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    func;
   logic [ssew_pkg::VAL_W-1:0]    seq;
   logic [ssew_pkg::VAL_W-1:0]    stamp;
   logic [ssew_pkg::VAL_W-1:0]    price;
   logic [ssew_pkg::VAL_W-1:0]    quantity;
   logic                          side;
   logic [ssew_pkg::RIDX_W-1:0]   read_index;

   modport source (output valid, func, seq, stamp, price, quantity, side, read_index,
                   input ready);
   modport sink (input valid, func, seq, stamp, price, quantity, side, read_index,
                 output ready);
endinterface

// ===== hw/rtl/ssew_rsp_if.sv =====
`timescale 1ns / 1ps

interface ssew_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           changed;
   logic [ssew_pkg::COUNT_W-1:0]   count;
   logic [ssew_pkg::MARK_W-1:0]    mark;
   logic                           rd_valid;
   logic [ssew_pkg::VAL_W-1:0]     rd_stamp;
   logic [ssew_pkg::VAL_W-1:0]     rd_price;
   logic [ssew_pkg::VAL_W-1:0]     rd_quantity;
   logic                           rd_side;

   modport source (output valid, changed, count, mark, rd_valid, rd_stamp, rd_price,
                   rd_quantity, rd_side, input ready);
   modport sink (input valid, changed, count, mark, rd_valid, rd_stamp, rd_price,
                 rd_quantity, rd_side, output ready);
endinterface

// ===== hw/rtl/ssew_cell.sv =====
`timescale 1ns / 1ps

module ssew_cell (
   input  logic                        clock,
   input  logic [ssew_pkg::IDX_W-1:0]  cell_idx,
   input  ssew_pkg::cell_cmd_type      cmd,
   input  logic                        prev_le,
   input  logic                        next_le,
   input  ssew_pkg::entry_type         prev_entry,
   input  ssew_pkg::entry_type         next_entry,
   output logic                        le,
   output ssew_pkg::entry_type         entry,
   output ssew_pkg::entry_type         rd_entry
);

   ssew_pkg::entry_type entry_ff;
   ssew_pkg::entry_type entry_in;
   logic                occupied;

   assign occupied = ssew_pkg::CMP_W'(cell_idx) < ssew_pkg::CMP_W'(cmd.count);
   assign le = occupied && (entry_ff.stamp <= cmd.rec.stamp);
   assign entry = entry_ff;
   assign rd_entry = (ssew_pkg::CMP_W'(cell_idx) == ssew_pkg::CMP_W'(cmd.read_index))
                     ? entry_ff : '0;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.full) begin
         // evict oldest: older part shifts down one place
         if (le && next_le) begin
            entry_in = next_entry;
         end else if (le) begin
            entry_in = cmd.rec;
         end
      end else begin
         // make room: newer part shifts up one place
         if (!le && prev_le) begin
            entry_in = cmd.rec;
         end else if (!le) begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_en) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== hw/rtl/ssew_read_tree.sv =====
`timescale 1ns / 1ps

module ssew_read_tree (
   input  logic                 clock,
   input  logic                 load,
   input  ssew_pkg::entry_type  cell_data [ssew_pkg::DEPTH],
   output ssew_pkg::entry_type  result
);

   ssew_pkg::entry_type grp_ff [ssew_pkg::NGRP];
   ssew_pkg::entry_type grp_in [ssew_pkg::NGRP];

   always_comb begin
      for (int g = 0; g < ssew_pkg::NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < ssew_pkg::GRP; k++) begin
            if (g * ssew_pkg::GRP + k < ssew_pkg::DEPTH) begin
               grp_in[g] = grp_in[g] | cell_data[g * ssew_pkg::GRP + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= grp_in;
      end
   end

   always_comb begin
      result = '0;
      for (int g = 0; g < ssew_pkg::NGRP; g++) begin
         result = result | grp_ff[g];
      end
   end

endmodule

// ===== hw/rtl/sequenced_sorted_event_window.sv =====
`timescale 1ns / 1ps

// sorted event window with sequence de-duplication
// req_chan carries one operation per transfer (func): gated append, sync append,
// heartbeat, clear or read. rsp_chan returns exactly one result per request, in order.
// records live in a chain of DEPTH cells, oldest first; an append compares the new
// timestamp in every cell at once and the cells shift toward or away from the
// insert point in the same cycle, so for append, heartbeat and clear the result is
// registered at the edge that takes the request.
// a read selects its entry through a two-level or-tree with one register level:
// the group results are registered first, then the result.
// a new request is taken while no read is in progress and the result register is
// empty or being drained; when the receiver stalls, the result holds and requests wait.
// reset (synchronous, active high) empties the window and zeroes the mark at once;
// stored entries need no clearing.
module sequenced_sorted_event_window (
   input  logic         clock,
   input  logic         reset,
   ssew_req_if.sink     req_chan,
   ssew_rsp_if.source   rsp_chan
);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                        state_ff, state_in;
   logic [ssew_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [ssew_pkg::MARK_W-1:0]      mark_ff, mark_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ssew_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic                             rd_valid_ff, rd_valid_in;

   logic                             out_free;
   logic                             req_fire;
   logic                             rec_valid;
   logic                             full;
   logic                             stored;
   logic                             ins_en;
   logic                             chg;
   logic [ssew_pkg::MARK_W-1:0]      seq_ext;
   logic [ssew_pkg::MARK_W-1:0]      next_mark;
   ssew_pkg::cell_cmd_type           cmd;
   ssew_pkg::entry_type              tree_result;

   logic                             le_v [ssew_pkg::DEPTH];
   ssew_pkg::entry_type              entry_v [ssew_pkg::DEPTH];
   ssew_pkg::entry_type              rd_v [ssew_pkg::DEPTH];

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign rec_valid = (req_chan.stamp != '0) && (req_chan.price != '0)
                      && (req_chan.quantity != '0);
   assign full = count_ff == ssew_pkg::CNT_W'(ssew_pkg::DEPTH);
   assign stored = rec_valid && (!full || le_v[0]);
   assign seq_ext = {1'b0, req_chan.seq};
   assign next_mark = seq_ext + ssew_pkg::MARK_W'(1);

   assign cmd.ins_en = ins_en;
   assign cmd.full = full;
   assign cmd.rec.stamp = req_chan.stamp;
   assign cmd.rec.price = req_chan.price;
   assign cmd.rec.quantity = req_chan.quantity;
   assign cmd.rec.side = req_chan.side;
   assign cmd.count = count_ff;
   assign cmd.read_index = req_chan.read_index;

   for (genvar i = 0; i < ssew_pkg::DEPTH; i++) begin : g_cell
      logic                 prev_le;
      logic                 next_le;
      ssew_pkg::entry_type  prev_entry;
      ssew_pkg::entry_type  next_entry;

      if (i == 0) begin : g_first
         assign prev_le = 1'b1;
         assign prev_entry = '0;
      end else begin : g_mid
         assign prev_le = le_v[i-1];
         assign prev_entry = entry_v[i-1];
      end

      if (i == ssew_pkg::DEPTH - 1) begin : g_last
         assign next_le = 1'b0;
         assign next_entry = '0;
      end else begin : g_inner
         assign next_le = le_v[i+1];
         assign next_entry = entry_v[i+1];
      end

      ssew_cell u_cell (
         .clock      (clock),
         .cell_idx   (ssew_pkg::IDX_W'(i)),
         .cmd        (cmd),
         .prev_le    (prev_le),
         .next_le    (next_le),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .le         (le_v[i]),
         .entry      (entry_v[i]),
         .rd_entry   (rd_v[i])
      );
   end

   ssew_read_tree u_read_tree (
      .clock     (clock),
      .load      (req_fire && (req_chan.func == ssew_pkg::FN_READ)),
      .cell_data (rd_v),
      .result    (tree_result)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      mark_in = mark_ff;
      rd_valid_in = rd_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in = rsp_data_ff;
      ins_en = 1'b0;
      chg = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.func)
                  ssew_pkg::FN_GATED, ssew_pkg::FN_SYNC: begin
                     if ((req_chan.func == ssew_pkg::FN_SYNC) || (seq_ext >= mark_ff)) begin
                        mark_in = next_mark;
                        ins_en = rec_valid;
                        chg = (next_mark != mark_ff) || stored;
                        if (stored && !full) begin
                           count_in = count_ff + ssew_pkg::CNT_W'(1);
                        end
                     end
                  end
                  ssew_pkg::FN_HEARTBEAT: begin
                     if (mark_ff != seq_ext) begin
                        count_in = '0;
                        mark_in = seq_ext;
                        chg = 1'b1;
                     end
                  end
                  ssew_pkg::FN_CLEAR: begin
                     chg = (count_ff != '0) || (mark_ff != '0);
                     count_in = '0;
                     mark_in = '0;
                  end
                  default: begin
                  end
               endcase

               if (req_chan.func == ssew_pkg::FN_READ) begin
                  rd_valid_in = ssew_pkg::CMP_W'(req_chan.read_index)
                                < ssew_pkg::CMP_W'(count_ff);
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = '0;
                  rsp_data_in.changed = chg;
                  rsp_data_in.count = ssew_pkg::COUNT_W'(count_in);
                  rsp_data_in.mark = mark_in;
               end
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               rsp_data_in.count = ssew_pkg::COUNT_W'(count_ff);
               rsp_data_in.mark = mark_ff;
               rsp_data_in.rd_valid = rd_valid_ff;
               rsp_data_in.rd = rd_valid_ff ? tree_result : '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         mark_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         mark_ff <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rd_valid_ff <= rd_valid_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.changed = rsp_data_ff.changed;
   assign rsp_chan.count = rsp_data_ff.count;
   assign rsp_chan.mark = rsp_data_ff.mark;
   assign rsp_chan.rd_valid = rsp_data_ff.rd_valid;
   assign rsp_chan.rd_stamp = rsp_data_ff.rd.stamp;
   assign rsp_chan.rd_price = rsp_data_ff.rd.price;
   assign rsp_chan.rd_quantity = rsp_data_ff.rd.quantity;
   assign rsp_chan.rd_side = rsp_data_ff.rd.side;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.func != ssew_pkg::FN_READ) |=> rsp_valid_ff)
      else $error("no result after non-read transfer");

   a_read_enters: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.func == ssew_pkg::FN_READ) |=> (state_ff == ST_READ))
      else $error("read did not enter read state");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.func == ssew_pkg::FN_CLEAR) |=>
         (count_ff == '0) && (mark_ff == '0))
      else $error("clear left state behind");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (count_ff == $past(count_ff))
                 || (count_ff == $past(count_ff) + ssew_pkg::CNT_W'(1))
                 || (count_ff == '0))
      else $error("count moved by more than one");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (count_ff <= ssew_pkg::CNT_W'(ssew_pkg::DEPTH)))
      else $error("count above depth");

endmodule
